FILE: hw/rtl/fvlm_pkg.sv
// ----------------------------------------------------------------------------
// fvlm_pkg
// Shared widths and cube helper functions for the four-variable minimizer.
// ----------------------------------------------------------------------------
package fvlm_pkg;

    localparam int NUM_VARS = 4;
    localparam int NUM_MT   = 16;
    // One stored prime: care mask, value, covered-minterm row.
    localparam int ENTRY_W  = 2 * NUM_VARS + NUM_MT;

    typedef logic [NUM_VARS-1:0] lit_t;
    typedef logic [NUM_MT-1:0]   mt_set_t;

    // Minterms that a cube spans.
    function automatic mt_set_t cube_mask(input lit_t care, input lit_t val);
        mt_set_t res;
        res = '0;
        for (int m = 0; m < NUM_MT; m++) begin
            res[m] = ((lit_t'(m) & care) == val);
        end
        return res;
    endfunction

    function automatic logic [2:0] pop4(input lit_t v);
        return 3'(v[0]) + 3'(v[1]) + 3'(v[2]) + 3'(v[3]);
    endfunction

endpackage

FILE: hw/rtl/fvlm_ram.sv
// ----------------------------------------------------------------------------
// fvlm_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module fvlm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/four_var_logic_minimizer_core.sv
// ----------------------------------------------------------------------------
// four_var_logic_minimizer_core
// Prime implicant generation, essential detection and cover selection for a
// 4-variable truth table; one result transaction per prime.
// ----------------------------------------------------------------------------
// Enumeration walks all 81 cubes once per 1-count class (0 to 4); the cover is
//   the essentials plus the first prime, if any, that covers every leftover minterm.
// A new truth table is accepted only in idle, after the last result is registered.
// All-zero table: a single empty-function result, issued once the output is free.
// Reset (aresetn low, synchronous): control returns to idle, output valid drops.
// ----------------------------------------------------------------------------
module four_var_logic_minimizer_core #(
    parameter int CUBE_DEPTH = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  fvlm_pkg::mt_set_t       s_truth_table,
    output logic                    m_valid,
    input  logic                    m_ready,
    output fvlm_pkg::lit_t          m_cube_value,
    output fvlm_pkg::lit_t          m_cube_care,
    output logic                    m_is_essential,
    output logic                    m_in_cover,
    output logic                    m_empty_function,
    output logic                    m_last_cube
);
    import fvlm_pkg::*;

    localparam int CAP = (CUBE_DEPTH < 32) ? CUBE_DEPTH : 32;
    localparam int AW  = $clog2(CUBE_DEPTH);
    localparam int NW  = $clog2(CAP + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ENUM  = 3'd1;
    localparam logic [2:0] ST_EMPTY = 3'd2;
    localparam logic [2:0] ST_COVER = 3'd3;
    localparam logic [2:0] ST_FIND  = 3'd4;
    localparam logic [2:0] ST_ORD   = 3'd5;
    localparam logic [2:0] ST_OLD   = 3'd6;

    localparam logic [7:0] DIG_ALL_ONE = 8'b10_10_10_10;

    logic [2:0]     st_reg, st_next;
    mt_set_t        tt_reg, tt_next;
    logic [2:0]     pcnt_reg, pcnt_next;
    logic [7:0]     dig_reg, dig_next;     // ternary digit per variable
    logic [NW-1:0]  np_reg, np_next;
    mt_set_t        once_reg, once_next;
    mt_set_t        multi_reg, multi_next;
    mt_set_t        covered_reg, covered_next;
    logic           chosen_vld_reg, chosen_vld_next;
    logic [NW-1:0]  chosen_idx_reg, chosen_idx_next;
    logic [NW-1:0]  rd_idx_reg, rd_idx_next;
    logic           dv_reg, dv_next;
    logic [NW-1:0]  dv_idx_reg, dv_idx_next;

    logic           m_valid_reg, m_valid_next;
    lit_t           val_o_reg, val_o_next;
    lit_t           care_o_reg, care_o_next;
    logic           ess_o_reg, ess_o_next;
    logic           cov_o_reg, cov_o_next;
    logic           empty_o_reg, empty_o_next;
    logic           last_o_reg, last_o_next;

    // RAM ports
    logic               ram_we;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
    lit_t               rd_care, rd_val;
    mt_set_t            rd_row;

    // enumeration datapath
    lit_t     e_care, e_val;
    mt_set_t  e_row;
    logic     e_impl, e_prime, e_hit;
    logic [7:0] dig_inc;
    logic     carry;

    mt_set_t  unique_mt, left_mt;
    logic     rd_en, sweep_done, out_free, rd_ess;

    fvlm_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(CUBE_DEPTH)
    ) u_prime_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (AW'(np_reg)),
        .wdata (ram_wdata),
        .raddr (AW'(rd_idx_reg)),
        .rdata (ram_rdata)
    );

    assign {rd_care, rd_val, rd_row} = ram_rdata;

    // Decode the current cube: rank 0 is a dash, 1 a zero literal, 2 a one.
    always_comb begin
        for (int v = 0; v < NUM_VARS; v++) begin
            e_care[v] = (dig_reg[2*v +: 2] != 2'd0);
            e_val[v]  = (dig_reg[2*v +: 2] == 2'd2);
        end
        e_row  = cube_mask(e_care, e_val);
        e_impl = ((e_row & ~tt_reg) == '0);
        // Prime when no cube with one literal fewer is still an implicant.
        e_prime = 1'b1;
        for (int v = 0; v < NUM_VARS; v++) begin
            if (e_care[v] &&
                ((cube_mask(e_care & ~lit_t'(1 << v), e_val & ~lit_t'(1 << v)) & ~tt_reg)
                 == '0)) begin
                e_prime = 1'b0;
            end
        end
        e_hit = (pop4(e_val) == pcnt_reg) && e_impl && e_prime;

        // Advance the base-3 counter, variable 0 as the least significant digit.
        carry   = 1'b1;
        dig_inc = dig_reg;
        for (int v = 0; v < NUM_VARS; v++) begin
            if (carry) begin
                if (dig_reg[2*v +: 2] == 2'd2) begin
                    dig_inc[2*v +: 2] = 2'd0;
                end else begin
                    dig_inc[2*v +: 2] = dig_reg[2*v +: 2] + 2'd1;
                    carry = 1'b0;
                end
            end
        end
    end

    assign ram_we    = (st_reg == ST_ENUM) && e_hit && (np_reg < NW'(CAP));
    assign ram_wdata = {e_care, e_val, e_row};

    // Minterms covered by exactly one prime, and what the essentials leave.
    assign unique_mt = once_reg & ~multi_reg;
    assign left_mt   = tt_reg & ~covered_reg;
    assign rd_ess    = |(rd_row & unique_mt);

    assign rd_en      = ((st_reg == ST_COVER) || (st_reg == ST_FIND)) && (rd_idx_reg < np_reg);
    assign sweep_done = (rd_idx_reg == np_reg) && !dv_reg;
    assign out_free   = !m_valid_reg || m_ready;

    always_comb begin
        st_next         = st_reg;
        tt_next         = tt_reg;
        pcnt_next       = pcnt_reg;
        dig_next        = dig_reg;
        np_next         = np_reg;
        once_next       = once_reg;
        multi_next      = multi_reg;
        covered_next    = covered_reg;
        chosen_vld_next = chosen_vld_reg;
        chosen_idx_next = chosen_idx_reg;
        rd_idx_next     = rd_idx_reg;
        dv_next         = 1'b0;
        dv_idx_next     = rd_idx_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        val_o_next      = val_o_reg;
        care_o_next     = care_o_reg;
        ess_o_next      = ess_o_reg;
        cov_o_next      = cov_o_reg;
        empty_o_next    = empty_o_reg;
        last_o_next     = last_o_reg;

        case (st_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    tt_next         = s_truth_table;
                    pcnt_next       = '0;
                    dig_next        = '0;
                    np_next         = '0;
                    once_next       = '0;
                    multi_next      = '0;
                    covered_next    = '0;
                    chosen_vld_next = 1'b0;
                    chosen_idx_next = '0;
                    st_next         = (s_truth_table == '0) ? ST_EMPTY : ST_ENUM;
                end
            end
            ST_ENUM: begin
                // Record each prime with its chart row; tally single/multiple cover.
                if (ram_we) begin
                    np_next    = np_reg + NW'(1);
                    multi_next = multi_reg | (once_reg & e_row);
                    once_next  = once_reg | e_row;
                end
                dig_next = dig_inc;
                if (dig_reg == DIG_ALL_ONE) begin
                    pcnt_next = pcnt_reg + 3'd1;
                    if (pcnt_reg == 3'(NUM_VARS)) begin
                        rd_idx_next = '0;
                        st_next     = ST_COVER;
                    end
                end
            end
            ST_EMPTY: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    val_o_next   = '0;
                    care_o_next  = '0;
                    ess_o_next   = 1'b0;
                    cov_o_next   = 1'b0;
                    empty_o_next = 1'b1;
                    last_o_next  = 1'b1;
                    st_next      = ST_IDLE;
                end
            end
            ST_COVER: begin
                if (rd_en) begin
                    rd_idx_next = rd_idx_reg + NW'(1);
                    dv_next     = 1'b1;
                end
                if (dv_reg && rd_ess) begin
                    covered_next = covered_reg | rd_row;
                end
                if (sweep_done) begin
                    rd_idx_next = '0;
                    st_next     = ST_FIND;
                end
            end
            ST_FIND: begin
                if (rd_en) begin
                    rd_idx_next = rd_idx_reg + NW'(1);
                    dv_next     = 1'b1;
                end
                // Keep the first prime that covers every leftover minterm.
                if (dv_reg && !chosen_vld_reg && (left_mt != '0) &&
                    ((rd_row & left_mt) == left_mt)) begin
                    chosen_vld_next = 1'b1;
                    chosen_idx_next = dv_idx_reg;
                end
                if (sweep_done) begin
                    rd_idx_next = '0;
                    st_next     = ST_ORD;
                end
            end
            ST_ORD: begin
                if (out_free) begin
                    st_next = ST_OLD;
                end
            end
            ST_OLD: begin
                m_valid_next = 1'b1;
                val_o_next   = rd_val;
                care_o_next  = rd_care;
                ess_o_next   = rd_ess;
                cov_o_next   = rd_ess || (chosen_vld_reg && (chosen_idx_reg == rd_idx_reg));
                empty_o_next = 1'b0;
                last_o_next  = (rd_idx_reg + NW'(1) == np_reg);
                rd_idx_next  = rd_idx_reg + NW'(1);
                st_next      = (rd_idx_reg + NW'(1) == np_reg) ? ST_IDLE : ST_ORD;
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg         <= ST_IDLE;
            np_reg         <= '0;
            rd_idx_reg     <= '0;
            dv_reg         <= 1'b0;
            chosen_vld_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            st_reg         <= st_next;
            np_reg         <= np_next;
            rd_idx_reg     <= rd_idx_next;
            dv_reg         <= dv_next;
            chosen_vld_reg <= chosen_vld_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Datapath registers hold their value without reset.
    always_ff @(posedge aclk) begin
        tt_reg         <= tt_next;
        pcnt_reg       <= pcnt_next;
        dig_reg        <= dig_next;
        once_reg       <= once_next;
        multi_reg      <= multi_next;
        covered_reg    <= covered_next;
        chosen_idx_reg <= chosen_idx_next;
        dv_idx_reg     <= dv_idx_next;
        val_o_reg      <= val_o_next;
        care_o_reg     <= care_o_next;
        ess_o_reg      <= ess_o_next;
        cov_o_reg      <= cov_o_next;
        empty_o_reg    <= empty_o_next;
        last_o_reg     <= last_o_next;
    end

    assign s_ready          = (st_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_cube_value     = val_o_reg;
    assign m_cube_care      = care_o_reg;
    assign m_is_essential   = ess_o_reg;
    assign m_in_cover       = cov_o_reg;
    assign m_empty_function = empty_o_reg;
    assign m_last_cube      = last_o_reg;

endmodule

FILE: hw/rtl/fvlm_checker.sv
// ----------------------------------------------------------------------------
// fvlm_checker
// Port-level checks on the result channel of the minimizer core.
// ----------------------------------------------------------------------------
module fvlm_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input fvlm_pkg::lit_t      m_cube_value,
    input fvlm_pkg::lit_t      m_cube_care,
    input logic                m_is_essential,
    input logic                m_in_cover,
    input logic                m_empty_function,
    input logic                m_last_cube
);
    import fvlm_pkg::*;

    // A stalled transaction holds its value, care, last and in-cover fields.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cube_value) && $stable(m_cube_care)
            && $stable(m_last_cube) && $stable(m_in_cover))
        else $error("result changed while stalled");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_empty_function |-> m_last_cube && (m_cube_value == '0)
            && (m_cube_care == '0) && !m_is_essential && !m_in_cover)
        else $error("empty-function result malformed");

    a_ess_cover: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_essential |-> m_in_cover)
        else $error("essential prime outside cover");

    a_dash_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_cube_value & ~m_cube_care) == '0)
        else $error("value bit set under a dash");

endmodule

bind four_var_logic_minimizer_core fvlm_checker u_fvlm_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_cube_value     (m_cube_value),
    .m_cube_care      (m_cube_care),
    .m_is_essential   (m_is_essential),
    .m_in_cover       (m_in_cover),
    .m_empty_function (m_empty_function),
    .m_last_cube      (m_last_cube)
);
